/* rtl/core/jacobi_stencil_residual_assert.svh */
// Assertion macros shared by the RTL modules.
`ifndef JACOBI_STENCIL_RESIDUAL_ASSERT_SVH
`define JACOBI_STENCIL_RESIDUAL_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/jsr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package jsr_pkg;

    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int VALUE_BITS_DEFAULT = 24;

    localparam int ROW_BITS          = 16;
    localparam int COL_OUT_BITS      = 10;
    localparam int RES_BITS          = 63;
    localparam int GRID_WIDTH_BITS   = 11;
    localparam int GRID_HEIGHT_BITS  = 16;
    localparam int CFG_DATA_BITS     = 16;
    localparam int CFG_INDEX_BITS    = 1;
    localparam int MIN_GRID_DIM      = 3;
    localparam int GRID_WIDTH_RESET  = 1024;
    localparam int GRID_HEIGHT_RESET = 1024;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_CELL     = 1'b0,
        KIND_RESIDUAL = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t                   kind;
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
    } ctl_t;

endpackage

`default_nettype wire

/* rtl/core/jsr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsr_front #(
    parameter int MAX_WIDTH  = jsr_pkg::MAX_WIDTH_DEFAULT,
    parameter int VALUE_BITS = jsr_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               take,
    input  wire logic signed [VALUE_BITS-1:0]       cell_value,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]       col_last,
    input  wire logic [jsr_pkg::ROW_BITS-1:0]       row_last,
    output logic                                    req_valid,
    output jsr_pkg::ctl_t                           req_ctl,
    output logic signed [VALUE_BITS+1:0]            req_sum,
    output logic signed [VALUE_BITS-1:0]            req_mid
);

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int VB = VALUE_BITS;

    logic [VB-1:0] cur_mem   [MAX_WIDTH];
    logic [VB-1:0] above_mem [MAX_WIDTH];

    logic [jsr_pkg::ROW_BITS-1:0] row_reg, row_next;
    logic [CB-1:0]                col_reg, col_next;
    logic [CB-1:0]                col_inc;
    logic                         interior, row_end, grid_end;

    logic signed [VB-1:0] mid_rd_reg, right_rd_reg, top_rd_reg;
    logic signed [VB-1:0] left_reg;
    logic signed [VB-1:0] f1_x_reg;
    logic [CB-1:0]        f1_col_reg;
    logic                 f1_valid_reg;
    logic                 f1_result_reg;
    jsr_pkg::ctl_t        f1_ctl_reg;

    // Window position of the arriving cell.
    always_comb
    begin
        col_inc  = CB'(col_reg + 1'b1);
        interior = (row_reg >= jsr_pkg::ROW_BITS'(2)) && (col_reg != '0)
                   && (col_reg < col_last);
        row_end  = (col_reg >= col_last);
        grid_end = row_end && (row_reg >= row_last);
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (take)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = grid_end ? '0 : jsr_pkg::ROW_BITS'(row_reg + 1'b1);
            end
            else
            begin
                col_next = col_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= take;
        end
    end

    // Current-row buffer: read center and right, overwrite center with the new cell.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mid_rd_reg       <= cur_mem[col_reg];
            right_rd_reg     <= cur_mem[col_inc];
            cur_mem[col_reg] <= cell_value;
        end
    end

    // Row-above buffer: read top now, retire the old center on the next cycle.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            top_rd_reg <= above_mem[col_reg];
        end
        if (f1_valid_reg)
        begin
            above_mem[f1_col_reg] <= mid_rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f1_x_reg       <= cell_value;
            f1_col_reg     <= col_reg;
            f1_result_reg  <= interior || grid_end;
            f1_ctl_reg.kind <= grid_end ? jsr_pkg::KIND_RESIDUAL : jsr_pkg::KIND_CELL;
            f1_ctl_reg.row  <= jsr_pkg::ROW_BITS'(row_reg - 1'b1);
            f1_ctl_reg.col  <= jsr_pkg::COL_OUT_BITS'(col_reg);
        end
        if (f1_valid_reg)
        begin
            left_reg <= mid_rd_reg;
        end
    end

    always_comb
    begin
        req_valid = f1_valid_reg && f1_result_reg;
        req_ctl   = f1_ctl_reg;
        req_mid   = mid_rd_reg;
        req_sum   = (VB+2)'(left_reg) + (VB+2)'(right_rd_reg)
                  + (VB+2)'(top_rd_reg) + (VB+2)'(f1_x_reg);
    end

endmodule

`default_nettype wire

/* rtl/core/jsr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module jsr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = jsr_pkg::QUEUE_DEPTH
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     wr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     rd,
    output logic [WIDTH-1:0]              rdata,
    output logic                          empty,
    output logic [$clog2(DEPTH):0]        count
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = (PW+1)'(count_reg + 1'b1);
        end
        else if (rd && !wr)
        begin
            count_next = (PW+1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (rd)
            begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

/* rtl/core/jsr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "jacobi_stencil_residual_assert.svh"

module jsr_back #(
    parameter int VALUE_BITS = jsr_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  wire jsr_pkg::ctl_t                      q_ctl,
    input  wire logic signed [VALUE_BITS+1:0]       q_sum,
    input  wire logic signed [VALUE_BITS-1:0]       q_mid,
    output logic                                    q_pop,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic signed [VALUE_BITS-1:0]            new_value,
    output logic [jsr_pkg::ROW_BITS-1:0]            center_row,
    output logic [jsr_pkg::COL_OUT_BITS-1:0]        center_col,
    output logic [jsr_pkg::RES_BITS-1:0]            residual,
    output logic                                    is_residual
);

    localparam int VB      = VALUE_BITS;
    localparam int SQ_BITS = 2 * VB;
    localparam int RB      = jsr_pkg::RES_BITS;
    localparam int SW      = ((SQ_BITS > RB) ? SQ_BITS : RB) + 1;

    logic en;

    logic                 b1_valid_reg;
    jsr_pkg::ctl_t        b1_ctl_reg;
    logic signed [VB-1:0] b1_nv_reg;
    logic signed [VB:0]   b1_diff_reg;
    logic signed [VB-1:0] nv;

    logic                 b2_valid_reg;
    jsr_pkg::ctl_t        b2_ctl_reg;
    logic signed [VB-1:0] b2_nv_reg;
    logic [SQ_BITS-1:0]   b2_sq_reg;
    logic signed [2*VB+1:0] prod;

    logic [RB-1:0] acc_reg, acc_next, acc_sat;
    logic [SW-1:0] acc_total;

    logic                              out_valid_reg;
    logic signed [VB-1:0]              new_value_reg;
    logic [jsr_pkg::ROW_BITS-1:0]      row_out_reg;
    logic [jsr_pkg::COL_OUT_BITS-1:0]  col_out_reg;
    logic [RB-1:0]                     residual_reg;
    logic                              is_residual_reg;

    logic b2_cell, b2_res;

    // Whole pipeline advances together whenever the output slot frees up.
    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;

    always_comb
    begin
        nv   = VB'(q_sum >>> 2);
        prod = b1_diff_reg * b1_diff_reg;
    end

    always_comb
    begin
        b2_cell   = b2_valid_reg && (b2_ctl_reg.kind == jsr_pkg::KIND_CELL);
        b2_res    = b2_valid_reg && (b2_ctl_reg.kind == jsr_pkg::KIND_RESIDUAL);
        acc_total = SW'(acc_reg) + SW'(b2_sq_reg);
        acc_sat   = (acc_total > SW'({RB{1'b1}})) ? {RB{1'b1}} : RB'(acc_total);
        acc_next  = acc_reg;
        if (en && b2_cell)
        begin
            acc_next = acc_sat;
        end
        else if (en && b2_res)
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            if (en)
            begin
                b1_valid_reg  <= !q_empty;
                b2_valid_reg  <= b1_valid_reg;
                out_valid_reg <= b2_valid_reg;
            end
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_ctl_reg  <= q_ctl;
            b1_nv_reg   <= nv;
            b1_diff_reg <= (VB+1)'(nv) - (VB+1)'(q_mid);

            b2_ctl_reg  <= b1_ctl_reg;
            b2_nv_reg   <= b1_nv_reg;
            b2_sq_reg   <= SQ_BITS'(prod);

            if (b2_res)
            begin
                new_value_reg   <= '0;
                row_out_reg     <= '0;
                col_out_reg     <= '0;
                residual_reg    <= acc_reg;
                is_residual_reg <= 1'b1;
            end
            else
            begin
                new_value_reg   <= b2_nv_reg;
                row_out_reg     <= b2_ctl_reg.row;
                col_out_reg     <= b2_ctl_reg.col;
                residual_reg    <= '0;
                is_residual_reg <= 1'b0;
            end
        end
    end

    assign empty       = !out_valid_reg;
    assign new_value   = new_value_reg;
    assign center_row  = row_out_reg;
    assign center_col  = col_out_reg;
    assign residual    = residual_reg;
    assign is_residual = is_residual_reg;

    `JSR_ASSERT_NEXT(a_acc_cleared, clk, rst_n, en && b2_res, acc_reg == '0, "residual not cleared")
    `JSR_ASSERT_NEXT(a_acc_grows, clk, rst_n, en && b2_cell, acc_reg >= $past(acc_reg), "residual shrank")
    `JSR_ASSERT_SAME(a_res_fields, clk, rst_n, out_valid_reg && is_residual_reg, new_value_reg == '0 && row_out_reg == '0 && col_out_reg == '0, "residual carries cell fields")

endmodule

`default_nettype wire

/* rtl/core/jacobi_stencil_residual.sv */
// Five-point Jacobi sweep over a streamed grid. Push one cell per cycle in row-major order;
// once the stream is past an interior cell's lower neighbor, the block queues that cell's new
// value (neighbor sum shifted right two, Q8.16) with its row and column, and after the last
// cell of the grid it queues the saturated sum of squared changes (Q31.32) with is_residual
// set, then starts the next grid. It takes one cell per cycle while full is low: the
// current-row line buffer has two read ports and one write port, and each cell uses each port
// once. A result moves through the front-end registers, the queue, b1, b2 and the output
// register. full rises only when the four-entry queue between the line-buffer front end
// and the arithmetic back end, plus the request in flight, would overflow, which happens
// only when pop is held low. Grid size is set through the configuration channel; the user
// must set it only while the block is idle, which the block does not enforce. Widths are
// clamped to 3..MAX_WIDTH, heights to at least 3. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "jacobi_stencil_residual_assert.svh"

module jacobi_stencil_residual #(
    parameter int MAX_WIDTH  = jsr_pkg::MAX_WIDTH_DEFAULT,
    parameter int VALUE_BITS = jsr_pkg::VALUE_BITS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [VALUE_BITS-1:0]         cell_value,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic signed [VALUE_BITS-1:0]              new_value,
    output logic [jsr_pkg::ROW_BITS-1:0]              center_row,
    output logic [jsr_pkg::COL_OUT_BITS-1:0]          center_col,
    output logic [jsr_pkg::RES_BITS-1:0]              residual,
    output logic                                      is_residual,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [jsr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [jsr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int CB   = $clog2(MAX_WIDTH);
    localparam int VB   = VALUE_BITS;
    localparam int QD   = jsr_pkg::QUEUE_DEPTH;
    localparam int QCW  = $clog2(QD) + 1;
    localparam int CTLW = $bits(jsr_pkg::ctl_t);
    localparam int QW   = CTLW + (VB + 2) + VB;
    localparam int RESET_COL_LAST =
        ((jsr_pkg::GRID_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : jsr_pkg::GRID_WIDTH_RESET) - 1;
    localparam int RESET_ROW_LAST = jsr_pkg::GRID_HEIGHT_RESET - 1;

    logic [CB-1:0]                col_last_reg, col_last_next;
    logic [jsr_pkg::ROW_BITS-1:0] row_last_reg, row_last_next;
    logic [jsr_pkg::GRID_WIDTH_BITS-1:0]  width_val;
    logic [jsr_pkg::GRID_HEIGHT_BITS-1:0] height_val;
    logic                         cfg_fire;

    logic                   take;
    logic                   q_wr;
    jsr_pkg::ctl_t          f_ctl;
    logic signed [VB+1:0]   f_sum;
    logic signed [VB-1:0]   f_mid;

    logic [QW-1:0]          q_wdata, q_rdata;
    logic                   q_rd, q_empty;
    logic [QCW-1:0]         q_count;
    jsr_pkg::ctl_t          q_ctl;
    logic signed [VB+1:0]   q_sum;
    logic signed [VB-1:0]   q_mid;

    // Configuration: keep the clamped last index of each dimension.
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign width_val  = cfg_data[jsr_pkg::GRID_WIDTH_BITS-1:0];
    assign height_val = cfg_data[jsr_pkg::GRID_HEIGHT_BITS-1:0];

    always_comb
    begin
        col_last_next = col_last_reg;
        row_last_next = row_last_reg;
        if (cfg_fire)
        begin
            case (jsr_pkg::cfg_reg_t'(cfg_index))
                jsr_pkg::REG_GRID_WIDTH:
                begin
                    if (32'(width_val) < 32'(jsr_pkg::MIN_GRID_DIM))
                    begin
                        col_last_next = CB'(jsr_pkg::MIN_GRID_DIM - 1);
                    end
                    else if (32'(width_val) > 32'(MAX_WIDTH))
                    begin
                        col_last_next = CB'(MAX_WIDTH - 1);
                    end
                    else
                    begin
                        col_last_next = CB'(width_val - 1'b1);
                    end
                end
                jsr_pkg::REG_GRID_HEIGHT:
                begin
                    if (32'(height_val) < 32'(jsr_pkg::MIN_GRID_DIM))
                    begin
                        row_last_next = jsr_pkg::ROW_BITS'(jsr_pkg::MIN_GRID_DIM - 1);
                    end
                    else
                    begin
                        row_last_next = jsr_pkg::ROW_BITS'(height_val - 1'b1);
                    end
                end
                default:
                begin
                    col_last_next = col_last_reg;
                    row_last_next = row_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_last_reg <= CB'(RESET_COL_LAST);
            row_last_reg <= jsr_pkg::ROW_BITS'(RESET_ROW_LAST);
        end
        else
        begin
            col_last_reg <= col_last_next;
            row_last_reg <= row_last_next;
        end
    end

    // Hold off new cells once queued plus in-flight requests would fill the queue.
    assign full = ((QCW+1)'(q_count) + (QCW+1)'(q_wr)) >= (QCW+1)'(QD);
    assign take = push && !full;

    jsr_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .cell_value (cell_value),
        .col_last   (col_last_reg),
        .row_last   (row_last_reg),
        .req_valid  (q_wr),
        .req_ctl    (f_ctl),
        .req_sum    (f_sum),
        .req_mid    (f_mid)
    );

    assign q_wdata = {f_ctl, f_sum, f_mid};

    jsr_queue #(
        .WIDTH (QW),
        .DEPTH (QD)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (q_wdata),
        .rd    (q_rd),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    assign q_ctl = jsr_pkg::ctl_t'(q_rdata[QW-1:2*VB+2]);
    assign q_sum = $signed(q_rdata[2*VB+1:VB]);
    assign q_mid = $signed(q_rdata[VB-1:0]);

    jsr_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_ctl       (q_ctl),
        .q_sum       (q_sum),
        .q_mid       (q_mid),
        .q_pop       (q_rd),
        .pop         (pop),
        .empty       (empty),
        .new_value   (new_value),
        .center_row  (center_row),
        .center_col  (center_col),
        .residual    (residual),
        .is_residual (is_residual)
    );

    `JSR_ASSERT_SAME(a_queue_room, clk, rst_n, q_wr, q_count < QCW'(QD), "request written into a full queue")
    `JSR_ASSERT_SAME(a_pop_has_data, clk, rst_n, q_rd, !q_empty, "request taken from an empty queue")

endmodule

`default_nettype wire

/* tb/sv/tb_jacobi_stencil_residual.sv */
`timescale 1ns / 1ps

module tb_jacobi_stencil_residual;

    import jsr_pkg::*;

    localparam int VALUE_W = VALUE_BITS_DEFAULT;
    localparam int LINE_LEN = MAX_WIDTH_DEFAULT;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int RANDOM_CELLS = 600;
    localparam int SETTLE_CYCLES = 12;
    localparam logic signed [VALUE_W-1:0] CELL_MAX = 24'sh7FFFFF;
    localparam logic signed [VALUE_W-1:0] CELL_MIN = 24'sh800000;
    localparam logic [63:0] RES_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_value;
        logic [ROW_BITS-1:0]       row;
        logic [COL_OUT_BITS-1:0]   col;
        logic [RES_BITS-1:0]       residual;
        kind_t                     kind;
    } sweep_result_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        bit                        typed;
        sweep_result_t             want;
    } directed_cell_t;

    typedef enum logic [1:0] {
        POP_ALWAYS,
        POP_HALF,
        POP_THIRD,
        POP_BLOCKED
    } pop_mode_t;

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic signed [VALUE_W-1:0] cell_value = '0;
    logic pop = 1'b0;
    logic cfg_valid = 1'b0;
    cfg_reg_t cfg_index = REG_GRID_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic full;
    logic empty;
    logic cfg_ready;
    logic signed [VALUE_W-1:0] new_value;
    logic [ROW_BITS-1:0] center_row;
    logic [COL_OUT_BITS-1:0] center_col;
    logic [RES_BITS-1:0] residual;
    logic is_residual;

    // Two 3x3 grids: a max plane with a min center, then a floor-rounding case.
    directed_cell_t directed_cells [18] = '{
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MIN, 1'b0, '0},
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MAX, 1'b0, '0},
        '{CELL_MAX, 1'b1, '{CELL_MAX, 16'd1, 10'd1, 63'd0, KIND_CELL}},
        '{CELL_MAX, 1'b1, '{24'sd0, 16'd0, 10'd0, 63'd281474943156225, KIND_RESIDUAL}},
        '{24'sd0, 1'b0, '0},
        '{24'sd0, 1'b0, '0},
        '{24'sd0, 1'b0, '0},
        '{-24'sd1, 1'b0, '0},
        '{24'sd5, 1'b0, '0},
        '{24'sd0, 1'b0, '0},
        '{24'sd0, 1'b0, '0},
        '{24'sd0, 1'b1, '{-24'sd1, 16'd1, 10'd1, 63'd0, KIND_CELL}},
        '{24'sd0, 1'b1, '{24'sd0, 16'd0, 10'd0, 63'd36, KIND_RESIDUAL}}
    };

    // Shadow of the block's grid state
    logic [GRID_WIDTH_BITS-1:0] width_reg = 11'(GRID_WIDTH_RESET);
    logic [GRID_HEIGHT_BITS-1:0] height_reg = 16'(GRID_HEIGHT_RESET);
    logic signed [VALUE_W-1:0] line_now [LINE_LEN] = '{default: '0};
    logic signed [VALUE_W-1:0] line_prev [LINE_LEN] = '{default: '0};
    int unsigned row_idx = 0;
    int unsigned col_idx = 0;
    logic [63:0] sq_sum = '0;
    longint left_old = 0;

    sweep_result_t stencil_results [$];
    sweep_result_t popped;
    int error_count = 0;
    int burst_left = 0;
    int unsigned cycle_count = 0;
    pop_mode_t pop_mode = POP_ALWAYS;
    int unsigned mode_left = 0;

    jacobi_stencil_residual u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cell_value  (cell_value),
        .empty       (empty),
        .pop         (pop),
        .new_value   (new_value),
        .center_row  (center_row),
        .center_col  (center_col),
        .residual    (residual),
        .is_residual (is_residual),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // Advance the sweep by one cell; returns 1 when the cell completes a result.
    function automatic bit stencil_step(input logic signed [VALUE_W-1:0] x,
                                        output sweep_result_t res);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        longint xv;
        longint mid;
        longint sum;
        longint nv;
        longint diff;
        longint sq;
        bit got;
        w = width_reg;
        h = height_reg;
        if (w < MIN_GRID_DIM) w = MIN_GRID_DIM;
        if (w > LINE_LEN) w = LINE_LEN;
        if (h < MIN_GRID_DIM) h = MIN_GRID_DIM;
        r = row_idx;
        c = col_idx;
        xv = x;
        mid = line_now[c];
        got = 1'b0;
        res = '0;
        if (r >= 2 && c >= 1 && c <= w - 2)
        begin
            sum = left_old + longint'(line_now[c + 1]) + longint'(line_prev[c]) + xv;
            nv = sum >>> 2;
            diff = nv - mid;
            sq = diff * diff;
            if (64'(sq) > RES_MAX - sq_sum)
                sq_sum = RES_MAX;
            else
                sq_sum = sq_sum + 64'(sq);
            res.new_value = nv[VALUE_W-1:0];
            res.row = ROW_BITS'(r - 1);
            res.col = COL_OUT_BITS'(c);
            res.kind = KIND_CELL;
            got = 1'b1;
        end
        left_old = mid;
        line_prev[c] = mid[VALUE_W-1:0];
        line_now[c] = x;
        if (c >= w - 1)
        begin
            col_idx = 0;
            if (r >= h - 1)
            begin
                res = '0;
                res.residual = sq_sum[RES_BITS-1:0];
                res.kind = KIND_RESIDUAL;
                got = 1'b1;
                sq_sum = '0;
                row_idx = 0;
            end
            else
                row_idx = r + 1;
        end
        else
            col_idx = c + 1;
        return got;
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_cell();
        logic [31:0] pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return CELL_MAX;
            1: return CELL_MIN;
            2: return VALUE_W'($signed($urandom_range(0, 8)) - 4);
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_GRID_WIDTH)
            width_reg = data[GRID_WIDTH_BITS-1:0];
        else
            height_reg = data[GRID_HEIGHT_BITS-1:0];
        // keep valid high when another write follows
        if (last)
            cfg_valid <= 1'b0;
    endtask

    task automatic push_cell(input logic signed [VALUE_W-1:0] v, input bit typed,
                             input sweep_result_t typed_res);
        sweep_result_t res;
        int gap;
        push <= 1'b1;
        cell_value <= v;
        @(posedge clk);
        while (full) @(posedge clk);
        if (stencil_step(v, res))
            stencil_results.push_back(typed ? typed_res : res);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop push, drain all pending results, then let boundary cells finish.
    task automatic settle();
        push <= 1'b0;
        while (stencil_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int random_cells;
        int w_data;
        int h_data;
        int n;
        random_cells = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Below-range width and height both act as 3.
        write_reg(REG_GRID_WIDTH, 16'd0, 1'b0);
        write_reg(REG_GRID_HEIGHT, 16'd1, 1'b1);
        foreach (directed_cells[i])
            push_cell(directed_cells[i].value, directed_cells[i].typed,
                      directed_cells[i].want);
        settle();

        while (random_cells < RANDOM_CELLS)
        begin
            w_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_data = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            write_reg(REG_GRID_WIDTH, CFG_DATA_BITS'(w_data), 1'b0);
            write_reg(REG_GRID_HEIGHT, CFG_DATA_BITS'(h_data), 1'b1);
            n = ((w_data < MIN_GRID_DIM) ? MIN_GRID_DIM : w_data)
                * ((h_data < MIN_GRID_DIM) ? MIN_GRID_DIM : h_data) * $urandom_range(1, 3);
            repeat (n) push_cell(random_cell(), 1'b0, '0);
            random_cells += n;
            settle();
        end

        // Tallest grid, cut short by lowering the height mid-grid.
        write_reg(REG_GRID_WIDTH, 16'd3, 1'b0);
        write_reg(REG_GRID_HEIGHT, 16'hFFFF, 1'b1);
        repeat (60) push_cell(random_cell(), 1'b0, '0);
        settle();
        write_reg(REG_GRID_HEIGHT, 16'd2, 1'b1);
        repeat (3) push_cell(random_cell(), 1'b0, '0);
        settle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (stencil_results.size() == 0)
                report_mismatch($sformatf("result with nothing pending (is_residual=%0b)",
                                          is_residual));
            else
            begin
                popped = stencil_results.pop_front();
                if (new_value !== popped.new_value)
                    report_mismatch($sformatf("new_value %0d, want %0d at row %0d col %0d",
                                              new_value, $signed(popped.new_value),
                                              popped.row, popped.col));
                if (center_row !== popped.row)
                    report_mismatch($sformatf("center_row %0d, want %0d", center_row,
                                              popped.row));
                if (center_col !== popped.col)
                    report_mismatch($sformatf("center_col %0d, want %0d", center_col,
                                              popped.col));
                if (residual !== popped.residual)
                    report_mismatch($sformatf("residual %0d, want %0d", residual,
                                              popped.residual));
                if (is_residual !== logic'(popped.kind))
                    report_mismatch($sformatf("is_residual %0b, want %0b", is_residual,
                                              popped.kind));
            end
        end
        if (mode_left == 0)
        begin
            pop_mode <= pop_mode_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (pop_mode)
            POP_ALWAYS: pop <= 1'b1;
            POP_HALF: pop <= 1'($urandom_range(0, 1));
            POP_THIRD: pop <= ($urandom_range(0, 2) == 0);
            // hold pop low while the low five bits of mode_left are below 20 so the queue fills
            default: pop <= (mode_left[4:0] >= 5'd20);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
